@@ hdl/famr_pkg.sv @@
// Shared types and constants for the fraction add/multiply/reduce block.
`default_nettype none

package famr_pkg;

    localparam int OPERAND_BITS_DEFAULT = 15;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_DEN,
        ST_MUL_N1,
        ST_MUL_N2,
        ST_ADD,
        ST_CHECK,
        ST_GCD,
        ST_DIV_NUM,
        ST_DIV_DEN,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

@@ hdl/fraction_add_multiply_reduce.sv @@
// Top level: adds or multiplies two fractions and reduces the result.
//
// A request is taken at a rising edge where start is high and busy is low. The
// inputs are the action (0 add, 1 multiply) and the two fractions. The block
// forms the products with one shared multiplier, adds the
// cross products for an add, then finds the GCD of numerator and denominator
// with a binary GCD loop that does one shift, swap or subtract per cycle.
// Both values are then divided by the GCD with restoring division, one
// quotient bit per cycle, on the same subtractor the GCD loop uses.
// A zero numerator or denominator skips the reduction.
// The result is shown for one cycle with o_done high; the receiver cannot
// stall it, and every beat must be taken in that cycle.
// A sum passes through one more state (ST_ADD) than a product. Unless the
// reduction is skipped, the GCD loop and then the numerator and denominator
// divisions follow before o_done. One request is in flight at a time and
// busy stays high until the cycle after o_done.
// Reset returns the sequencer to idle; no result is pending after reset.
`default_nettype none

module fraction_add_multiply_reduce #(
    parameter int OPERAND_BITS = famr_pkg::OPERAND_BITS_DEFAULT
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    input  wire logic                        i_action,
    input  wire logic [OPERAND_BITS-1:0]     i_first_num,
    input  wire logic [OPERAND_BITS-1:0]     i_first_den,
    input  wire logic [OPERAND_BITS-1:0]     i_second_num,
    input  wire logic [OPERAND_BITS-1:0]     i_second_den,
    output logic                             busy,
    output logic                             o_done,
    output logic [2*OPERAND_BITS:0]          o_result_num,
    output logic [2*OPERAND_BITS-1:0]        o_result_den
);

    localparam int W  = OPERAND_BITS;
    localparam int NW = 2 * OPERAND_BITS + 1;
    localparam int DW = 2 * OPERAND_BITS;
    localparam int KW = $clog2(NW + 1);
    localparam int CW = $clog2(NW);

    famr_pkg::t_state r_state, n_state;

    logic          r_action, n_action;
    logic [W-1:0]  r_an, n_an, r_ad, n_ad, r_bn, n_bn, r_bd, n_bd;
    logic [NW-1:0] r_num, n_num;
    logic [DW-1:0] r_den, n_den;
    logic [NW-1:0] r_x, n_x, r_y, n_y;
    logic [KW-1:0] r_k, n_k;
    logic [DW-1:0] r_g, n_g;
    logic [NW-1:0] r_rem, n_rem, r_quo, n_quo;
    logic [CW-1:0] r_cnt, n_cnt;

    logic [W-1:0]  mul_a, mul_b;
    logic [DW-1:0] prod;
    logic [NW-1:0] sub_a, sub_b, sub_diff;
    logic          sub_borrow;
    logic [NW-1:0] rem_sh, quo_step, rem_step, g_full;
    logic          div_last;

    famr_mul #(.W(W)) u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    famr_sub #(.NW(NW)) u_sub (
        .i_a      (sub_a),
        .i_b      (sub_b),
        .o_diff   (sub_diff),
        .o_borrow (sub_borrow)
    );

    assign rem_sh   = {r_rem[NW-2:0], r_quo[NW-1]};
    assign quo_step = {r_quo[NW-2:0], ~sub_borrow};
    assign rem_step = sub_borrow ? rem_sh : sub_diff;
    assign g_full   = (r_x | r_y) << r_k;
    assign div_last = (r_cnt == CW'(NW - 1));

    always_comb begin
        unique case (r_state)
            famr_pkg::ST_MUL_DEN: begin
                mul_a = r_ad;
                mul_b = r_bd;
            end
            famr_pkg::ST_MUL_N1: begin
                mul_a = r_an;
                mul_b = r_action ? r_bn : r_bd;
            end
            default: begin
                mul_a = r_bn;
                mul_b = r_ad;
            end
        endcase
    end

    always_comb begin
        if (r_state == famr_pkg::ST_GCD) begin
            sub_a = r_x;
            sub_b = r_y;
        end else begin
            sub_a = rem_sh;
            sub_b = NW'(r_g);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            famr_pkg::ST_IDLE:    if (start) n_state = famr_pkg::ST_MUL_DEN;
            famr_pkg::ST_MUL_DEN: n_state = famr_pkg::ST_MUL_N1;
            famr_pkg::ST_MUL_N1:  n_state = famr_pkg::ST_MUL_N2;
            famr_pkg::ST_MUL_N2: begin
                n_state = r_action ? famr_pkg::ST_CHECK : famr_pkg::ST_ADD;
            end
            famr_pkg::ST_ADD:     n_state = famr_pkg::ST_CHECK;
            famr_pkg::ST_CHECK: begin
                if (r_num == '0 || r_den == '0) begin
                    n_state = famr_pkg::ST_DONE;
                end else begin
                    n_state = famr_pkg::ST_GCD;
                end
            end
            famr_pkg::ST_GCD:     if (r_x == '0 || r_y == '0) n_state = famr_pkg::ST_DIV_NUM;
            famr_pkg::ST_DIV_NUM: if (div_last) n_state = famr_pkg::ST_DIV_DEN;
            famr_pkg::ST_DIV_DEN: if (div_last) n_state = famr_pkg::ST_DONE;
            famr_pkg::ST_DONE:    n_state = famr_pkg::ST_IDLE;
            default:              n_state = famr_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_action = r_action;
        n_an     = r_an;
        n_ad     = r_ad;
        n_bn     = r_bn;
        n_bd     = r_bd;
        n_num    = r_num;
        n_den    = r_den;
        n_x      = r_x;
        n_y      = r_y;
        n_k      = r_k;
        n_g      = r_g;
        n_rem    = r_rem;
        n_quo    = r_quo;
        n_cnt    = r_cnt;
        unique case (r_state)
            famr_pkg::ST_IDLE: begin
                if (start) begin
                    n_action = i_action;
                    n_an     = i_first_num;
                    n_ad     = i_first_den;
                    n_bn     = i_second_num;
                    n_bd     = i_second_den;
                end
            end
            famr_pkg::ST_MUL_N1: n_den = prod;
            famr_pkg::ST_MUL_N2: n_num = NW'(prod);
            famr_pkg::ST_ADD:    n_num = r_num + NW'(prod);
            famr_pkg::ST_CHECK: begin
                n_x = r_num;
                n_y = NW'(r_den);
                n_k = '0;
            end
            famr_pkg::ST_GCD: begin
                priority if (r_x == '0 || r_y == '0) begin
                    n_g   = g_full[DW-1:0];
                    n_rem = '0;
                    n_quo = r_num;
                    n_cnt = '0;
                end else if (!r_x[0] && !r_y[0]) begin
                    n_x = r_x >> 1;
                    n_y = r_y >> 1;
                    n_k = r_k + KW'(1);
                end else if (!r_x[0]) begin
                    n_x = r_x >> 1;
                end else if (!r_y[0]) begin
                    n_y = r_y >> 1;
                end else if (!sub_borrow) begin
                    n_x = sub_diff;
                end else begin
                    n_x = r_y;
                    n_y = r_x;
                end
            end
            famr_pkg::ST_DIV_NUM: begin
                n_rem = rem_step;
                n_quo = quo_step;
                n_cnt = r_cnt + CW'(1);
                if (div_last) begin
                    n_num = quo_step;
                    n_rem = '0;
                    n_quo = NW'(r_den);
                    n_cnt = '0;
                end
            end
            famr_pkg::ST_DIV_DEN: begin
                n_rem = rem_step;
                n_quo = quo_step;
                n_cnt = r_cnt + CW'(1);
                if (div_last) begin
                    n_den = quo_step[DW-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= famr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action <= n_action;
        r_an     <= n_an;
        r_ad     <= n_ad;
        r_bn     <= n_bn;
        r_bd     <= n_bd;
        r_num    <= n_num;
        r_den    <= n_den;
        r_x      <= n_x;
        r_y      <= n_y;
        r_k      <= n_k;
        r_g      <= n_g;
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_cnt    <= n_cnt;
    end

    always_comb begin
        busy         = (r_state != famr_pkg::ST_IDLE);
        o_done       = (r_state == famr_pkg::ST_DONE);
        o_result_num = r_num;
        o_result_den = r_den;
    end

    // A finished beat always returns the block to idle on the next cycle.
    a_done_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy)
        else $error("block still busy after result beat");

    a_start_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_gcd_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == famr_pkg::ST_GCD) |-> (r_x != '0 || r_y != '0))
        else $error("GCD operands both zero");

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == famr_pkg::ST_DIV_NUM || r_state == famr_pkg::ST_DIV_DEN)
        |-> (r_rem < NW'(r_g)))
        else $error("division remainder not below divisor");

endmodule

`default_nettype wire

@@ hdl/famr_mul.sv @@
// Registered operand multiplier shared by the three product steps.
`default_nettype none

module famr_mul #(
    parameter int W = famr_pkg::OPERAND_BITS_DEFAULT
) (
    input  wire logic             i_clk,
    input  wire logic [W-1:0]     i_a,
    input  wire logic [W-1:0]     i_b,
    output logic      [2*W-1:0]   o_prod
);

    localparam int PW = 2 * W;

    logic [PW-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= PW'(i_a) * PW'(i_b);
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

@@ hdl/famr_sub.sv @@
// Shared subtract and compare unit used by the GCD loop and both divisions.
`default_nettype none

module famr_sub #(
    parameter int NW = 2 * famr_pkg::OPERAND_BITS_DEFAULT + 1
) (
    input  wire logic [NW-1:0] i_a,
    input  wire logic [NW-1:0] i_b,
    output logic      [NW-1:0] o_diff,
    output logic               o_borrow
);

    logic [NW:0] full;

    assign full     = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff   = full[NW-1:0];
    assign o_borrow = full[NW];

endmodule

`default_nettype wire

@@ tb/fraction_add_multiply_reduce_tb.sv @@
// Self-checking testbench for the fraction add/multiply/reduce block.
`default_nettype none

module fraction_add_multiply_reduce_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W = famr_pkg::OPERAND_BITS_DEFAULT;
    localparam int OPERAND_MAX = (1 << W) - 1;
    localparam bit ACT_ADD = 1'b0;
    localparam bit ACT_MUL = 1'b1;
    localparam int RANDOM_REQUESTS = 430;
    localparam int SETTLE_CYCLES = 200;
    localparam int STALL_LIMIT = 5000;

    typedef logic [W-1:0] t_operand;
    typedef struct packed {
        logic [2*W:0]   num;
        logic [2*W-1:0] den;
    } t_fraction;

    class fraction_board;
        t_fraction awaited[$];
        int        failures;

        function new();
            failures = 0;
        endfunction

        function void note_request(logic mul, t_operand a_num, t_operand a_den,
                                   t_operand b_num, t_operand b_den);
            longint unsigned num;
            longint unsigned den;
            longint unsigned x;
            longint unsigned y;
            longint unsigned r;
            t_fraction       f;
            den = 64'(a_den) * 64'(b_den);
            if (mul == ACT_MUL) begin
                num = 64'(a_num) * 64'(b_num);
            end else begin
                num = 64'(a_num) * 64'(b_den) + 64'(b_num) * 64'(a_den);
            end
            if (num != 0 && den != 0) begin
                x = num;
                y = den;
                while (y != 0) begin
                    r = x % y;
                    x = y;
                    y = r;
                end
                num = num / x;
                den = den / x;
            end
            f.num = num[2*W:0];
            f.den = den[2*W-1:0];
            awaited.push_back(f);
        endfunction

        function void check_result(logic [2*W:0] num, logic [2*W-1:0] den);
            t_fraction f;
            if (awaited.size() == 0) begin
                $error("result %0d/%0d arrived with no request outstanding", num, den);
                failures++;
                return;
            end
            f = awaited.pop_front();
            if (num !== f.num) begin
                $error("result_num: expected %0d, actual %0d", f.num, num);
                failures++;
            end
            if (den !== f.den) begin
                $error("result_den: expected %0d, actual %0d", f.den, den);
                failures++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           start = 1'b0;
    logic           i_action = ACT_ADD;
    t_operand       i_first_num = '0;
    t_operand       i_first_den = '0;
    t_operand       i_second_num = '0;
    t_operand       i_second_den = '0;
    logic           busy;
    logic           o_done;
    logic [2*W:0]   o_result_num;
    logic [2*W-1:0] o_result_den;

    fraction_board board;
    int            stall_count = 0;

    fraction_add_multiply_reduce #(
        .OPERAND_BITS(W)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_action    (i_action),
        .i_first_num (i_first_num),
        .i_first_den (i_first_den),
        .i_second_num(i_second_num),
        .i_second_den(i_second_den),
        .busy        (busy),
        .o_done      (o_done),
        .o_result_num(o_result_num),
        .o_result_den(o_result_den)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done === 1'b1) begin
                board.check_result(o_result_num, o_result_den);
            end
            if ((start && busy === 1'b0) || o_done === 1'b1) begin
                stall_count <= 0;
            end else if (stall_count >= STALL_LIMIT) begin
                $display("FAIL fraction_add_multiply_reduce");
                $finish;
            end else begin
                stall_count <= stall_count + 1;
            end
        end
    end

    // Start stays high after the beat is taken so that a back-to-back request
    // never lowers and raises it within one step.
    task automatic send_request(logic mul, t_operand a_num, t_operand a_den,
                                t_operand b_num, t_operand b_den);
        start        <= 1'b1;
        i_action     <= mul;
        i_first_num  <= a_num;
        i_first_den  <= a_den;
        i_second_num <= b_num;
        i_second_den <= b_den;
        do @(posedge i_clk); while (busy !== 1'b0);
        board.note_request(mul, a_num, a_den, b_num, b_den);
    endtask

    task automatic hold_off(int cycles);
        if (cycles > 0) begin
            start <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    function automatic int pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    function automatic t_operand pick_operand(bit allow_zero);
        int unsigned mode;
        int unsigned lo;
        mode = $urandom_range(0, 9);
        lo = allow_zero ? 0 : 1;
        case (mode)
            0, 1, 2, 3, 4: begin
                return t_operand'($urandom_range(lo, OPERAND_MAX));
            end
            5, 6, 7: begin
                return t_operand'($urandom_range(lo, 40));
            end
            8: begin
                if ($urandom_range(0, 1) == 1) begin
                    return t_operand'(1 << $urandom_range(0, W - 1));
                end
                return t_operand'(12 * $urandom_range(1, OPERAND_MAX / 12));
            end
            default: begin
                return allow_zero ? t_operand'(0) : t_operand'(OPERAND_MAX);
            end
        endcase
    endfunction

    initial begin
        t_operand max_op;
        int       gap;
        max_op = t_operand'(OPERAND_MAX);
        board = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(ACT_ADD, 0, 1, 0, 1);
        send_request(ACT_MUL, 0, 1, 0, 1);
        send_request(ACT_ADD, max_op, max_op, max_op, max_op);
        send_request(ACT_MUL, max_op, max_op, max_op, max_op);
        send_request(ACT_ADD, max_op, max_op - t_operand'(1), max_op,
                     max_op - t_operand'(2));
        send_request(ACT_MUL, max_op, 1, max_op, 1);
        send_request(ACT_MUL, 1, max_op, 1, max_op);
        hold_off(3);
        send_request(ACT_ADD, 0, 3, 0, 5);
        send_request(ACT_MUL, 0, max_op, 7, 2);
        send_request(ACT_ADD, 0, 6, 4, 8);
        send_request(ACT_ADD, 3, 0, 5, 7);
        send_request(ACT_MUL, 3, 5, 4, 0);
        send_request(ACT_ADD, 1, 0, 1, 0);
        send_request(ACT_ADD, 1, 2, 1, 3);
        send_request(ACT_ADD, 1, 2, 1, 2);
        send_request(ACT_MUL, 6, 4, 10, 15);
        send_request(ACT_ADD, 15'h5555, 15'h2aaa, 15'h2aaa, 15'h5555);
        send_request(ACT_MUL, 15'h2aaa, 15'h5555, 15'h5555, 15'h2aaa);
        send_request(ACT_ADD, 1, 1, 0, 1);
        send_request(ACT_MUL, 12, 18, 1, 1);
        send_request(ACT_ADD, 16384, 16384, 16384, 8192);
        send_request(ACT_MUL, 8192, 3, 4, 16384);
        wait_drained();

        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            if (i == 120 || i == 320) begin
                wait_drained();
            end
            send_request($urandom_range(0, 1) == 1 ? ACT_MUL : ACT_ADD,
                         pick_operand(1'b1), pick_operand(1'b0),
                         pick_operand(1'b1), pick_operand(1'b0));
            gap = (i >= 200 && i < 240) ? 0 : pick_gap();
            hold_off(gap);
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (board.pending() != 0) begin
            $error("%0d results never arrived", board.pending());
            board.failures++;
        end
        if (board.failures == 0) begin
            $display("PASS fraction_add_multiply_reduce");
        end else begin
            $display("FAIL fraction_add_multiply_reduce");
        end
        $finish;
    end

endmodule

`default_nettype wire
